[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on i_clk, held off during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication checked at every rising edge outside reset
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (prop)) else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error(msg);

`endif

[sv/b32d_pkg.sv]
// ---------------------------------------------------------------------------
// b32d_pkg
// types, constants and the symbol lookup for the base32 invite-code decoder
// ---------------------------------------------------------------------------
package b32d_pkg;

    // code geometry
    localparam int unsigned CODE_LENGTH = 10;
    localparam int unsigned ACC_W       = 48;
    localparam int unsigned SYM_W       = 5;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned PORT_W      = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_CODE = COUNT_W'(CODE_LENGTH);

    // alphabet, first character in the top byte
    localparam logic [255:0] ALPHABET = "ABCDEFGHJKLMNPQRSTUVWXYZ23456789";

    // ascii bounds for case folding
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    // one mapped character, passed from lookup to accumulator
    typedef struct packed {
        logic [SYM_W-1:0] value;
        logic             bad;
        logic             last;
    } t_sym_word;

    // lookup result
    typedef struct packed {
        logic             hit;
        logic [SYM_W-1:0] value;
    } t_lookup;

    // fold to upper case and search the alphabet
    function automatic t_lookup symbol_lookup(input logic [7:0] symbol);
        logic [7:0] ch;
        t_lookup    res;
        ch        = symbol;
        res.hit   = 1'b0;
        res.value = '0;
        if (ch >= LOWER_A && ch <= LOWER_Z) begin
            ch = ch - CASE_DELTA;
        end
        for (int i = 0; i < 32; i++) begin
            if (ch == ALPHABET[255 - 8*i -: 8]) begin
                res.hit   = 1'b1;
                res.value = SYM_W'(i);
            end
        end
        return res;
    endfunction

endpackage

[sv/b32d_lookup.sv]
// ---------------------------------------------------------------------------
// b32d_lookup
// input stage: maps each character to its 5-bit value and registers it
// ---------------------------------------------------------------------------
module b32d_lookup (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_symbol,
    input  logic               i_last,
    output logic               o_dn_valid,
    input  logic               i_dn_ready,
    output b32d_pkg::t_sym_word o_dn_word
);
    import b32d_pkg::*;

    logic      r_valid;
    t_sym_word r_word;
    t_lookup   look;
    logic      accept;

    // stage takes a new word when empty or when its word leaves
    assign o_ready = !r_valid || i_dn_ready;
    assign accept  = i_valid && o_ready;
    assign look    = symbol_lookup(i_symbol);

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // mapped character, value forced to zero when not in the alphabet
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word.value <= look.hit ? look.value : '0;
            r_word.bad   <= !look.hit;
            r_word.last  <= i_last;
        end
    end

    assign o_dn_valid = r_valid;
    assign o_dn_word  = r_word;

endmodule

[sv/b32d_accum.sv]
// ---------------------------------------------------------------------------
// b32d_accum
// shifts values into the accumulator and registers one result per code
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module b32d_accum #(
    parameter int unsigned CODE_LENGTH = b32d_pkg::CODE_LENGTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_up_valid,
    output logic                          o_up_ready,
    input  b32d_pkg::t_sym_word           i_up_word,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_valid_res,
    output logic [b32d_pkg::ADDR_W-1:0]   o_ipv4_address,
    output logic [b32d_pkg::PORT_W-1:0]   o_port_number
);
    import b32d_pkg::*;

    // count that marks a complete code
    localparam logic [COUNT_W-1:0] CODE_COUNT = COUNT_W'(CODE_LENGTH);

    logic [ACC_W-1:0]   r_acc;
    logic [COUNT_W-1:0] r_count;
    logic               r_bad;
    logic [ACC_W-1:0]   n_acc;
    logic [COUNT_W-1:0] n_count;
    logic               n_bad;
    logic               code_ok;
    logic               accept;

    logic               r_out_valid;
    logic               r_out_res;
    logic [ADDR_W-1:0]  r_out_addr;
    logic [PORT_W-1:0]  r_out_port;

    // result register frees up when empty or when taken
    assign o_up_ready = !r_out_valid || i_ready;
    assign accept     = i_up_valid && o_up_ready;

    // next accumulator state for the incoming word
    always_comb begin
        n_acc   = {r_acc[ACC_W-SYM_W-1:0], i_up_word.value};
        n_count = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_W'(1);
        n_bad   = r_bad || i_up_word.bad;
        code_ok = !n_bad && (n_count == CODE_COUNT);
    end

    // accumulator state, cleared after the final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_count <= '0;
            r_bad   <= 1'b0;
        end else if (accept) begin
            if (i_up_word.last) begin
                r_acc   <= '0;
                r_count <= '0;
                r_bad   <= 1'b0;
            end else begin
                r_acc   <= n_acc;
                r_count <= n_count;
                r_bad   <= n_bad;
            end
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_up_ready) begin
            r_out_valid <= i_up_valid && i_up_word.last;
        end
    end

    // result payload, zeros for an invalid code
    always_ff @(posedge i_clk) begin
        if (accept && i_up_word.last) begin
            r_out_res  <= code_ok;
            r_out_addr <= code_ok ? n_acc[ACC_W-1:PORT_W] : '0;
            r_out_port <= code_ok ? n_acc[PORT_W-1:0] : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_valid_res    = r_out_res;
    assign o_ipv4_address = r_out_addr;
    assign o_port_number  = r_out_port;

    // checks
    `ASSERT_IMPLY(a_invalid_is_zero, r_out_valid && !r_out_res,
        r_out_addr == '0 && r_out_port == '0, "invalid result carries data")
    `ASSERT_NEXT(a_clear_after_last, accept && i_up_word.last,
        r_count == '0 && !r_bad && r_acc == '0, "state not cleared after last")
    `ASSERT_NEXT(a_count_advances, accept && !i_up_word.last,
        r_count != '0, "count did not advance")
    `ASSERT_NEXT(a_result_only_on_last, !r_out_valid && !(accept && i_up_word.last),
        !r_out_valid, "result without a final character")

endmodule

[sv/base32_endpoint_code_decoder.sv]
// ---------------------------------------------------------------------------
// base32_endpoint_code_decoder
// decodes a base32 invite code into an ipv4 address and port
// ---------------------------------------------------------------------------
// Input channel: one ASCII character per word (i_symbol), with i_last set on
// the final character, moved by i_valid / o_ready. Letters fold to upper case
// and map through the alphabet that leaves out I, O, 0 and 1.
// Output channel: one word per code, moved by o_valid / i_ready, giving
// o_valid_res and, for a valid code, the address from accumulator bits 47..16
// and the port from bits 15..0; an invalid code gives zeros.
// A code is valid with exactly CODE_LENGTH characters, all in the alphabet.
// A final character passes the lookup register, then the result register that
// raises o_valid. Throughput: one character per cycle while i_ready is high,
// as the lookup stage and the result register each pass one word per cycle.
// Reset clears the accumulator, count, error flag and both valid flags.
// When the receiver stalls the result holds, the lookup stage fills, and
// o_ready drops; no word is lost or repeated.
// ---------------------------------------------------------------------------
module base32_endpoint_code_decoder #(
    parameter int unsigned CODE_LENGTH = b32d_pkg::CODE_LENGTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_symbol,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_valid_res,
    output logic [b32d_pkg::ADDR_W-1:0]   o_ipv4_address,
    output logic [b32d_pkg::PORT_W-1:0]   o_port_number
);
    import b32d_pkg::*;

    logic      sym_valid;
    logic      sym_ready;
    t_sym_word sym_word;

    // character lookup stage
    b32d_lookup u_lookup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_symbol   (i_symbol),
        .i_last     (i_last),
        .o_dn_valid (sym_valid),
        .i_dn_ready (sym_ready),
        .o_dn_word  (sym_word)
    );

    // accumulator and result stage
    b32d_accum #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_accum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_up_valid     (sym_valid),
        .o_up_ready     (sym_ready),
        .i_up_word      (sym_word),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_valid_res    (o_valid_res),
        .o_ipv4_address (o_ipv4_address),
        .o_port_number  (o_port_number)
    );

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the base32 invite-code decoder
// ---------------------------------------------------------------------------
// A directed table covers the alphabet extremes, mixed letter case, and single
// character codes made of bytes outside the alphabet. A random part follows,
// made mostly of well-formed codes with random content, plus codes with a bad
// character, codes of random length (past the count saturation too), and
// raw byte noise. A bench-side decoder predicts each result the table does not
// type in. Both channels idle at random, except through one long steady stretch.
// ---------------------------------------------------------------------------
module tb;
    import b32d_pkg::*;

    localparam int unsigned RANDOM_WORDS = 2000;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned IDLE_PCT     = 18;

    // one decoded endpoint as the output channel gives it
    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } t_endpoint;

    // one row of the directed table
    typedef struct packed {
        logic [7:0] sym;
        logic       last;
        logic       typed;
        t_endpoint  want;
    } t_stim_row;

    localparam t_endpoint NO_ENDPOINT  = '0;
    localparam t_endpoint ALL_ONES_EP  = '{1'b1, 32'hFFFF_FFFF, 16'hFFFF};

    localparam int unsigned DIRECTED_ROWS = 24;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // mixed case code, checked by the decoder model
        '{8'h61, 1'b0, 1'b0, NO_ENDPOINT},  // a
        '{8'h42, 1'b0, 1'b0, NO_ENDPOINT},  // B
        '{8'h63, 1'b0, 1'b0, NO_ENDPOINT},  // c
        '{8'h44, 1'b0, 1'b0, NO_ENDPOINT},  // D
        '{8'h68, 1'b0, 1'b0, NO_ENDPOINT},  // h
        '{8'h4A, 1'b0, 1'b0, NO_ENDPOINT},  // J
        '{8'h6E, 1'b0, 1'b0, NO_ENDPOINT},  // n
        '{8'h50, 1'b0, 1'b0, NO_ENDPOINT},  // P
        '{8'h7A, 1'b0, 1'b0, NO_ENDPOINT},  // z
        '{8'h32, 1'b1, 1'b0, NO_ENDPOINT},  // 2
        // top symbol everywhere, accumulator all ones
        '{8'h39, 1'b0, 1'b0, NO_ENDPOINT},
        '{8'h39, 1'b0, 1'b0, NO_ENDPOINT},
        '{8'h39, 1'b0, 1'b0, NO_ENDPOINT},
        '{8'h39, 1'b0, 1'b0, NO_ENDPOINT},
        '{8'h39, 1'b0, 1'b0, NO_ENDPOINT},
        '{8'h39, 1'b0, 1'b0, NO_ENDPOINT},
        '{8'h39, 1'b0, 1'b0, NO_ENDPOINT},
        '{8'h39, 1'b0, 1'b0, NO_ENDPOINT},
        '{8'h39, 1'b0, 1'b0, NO_ENDPOINT},
        '{8'h39, 1'b1, 1'b1, ALL_ONES_EP},
        // one-character codes outside the alphabet, all give zeros
        '{8'h00, 1'b1, 1'b1, NO_ENDPOINT},
        '{8'hFF, 1'b1, 1'b1, NO_ENDPOINT},
        '{8'h49, 1'b1, 1'b1, NO_ENDPOINT},  // I
        '{8'h6F, 1'b1, 1'b1, NO_ENDPOINT}   // o
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [7:0]        i_symbol = '0;
    logic              i_last = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_valid_res;
    logic [ADDR_W-1:0] o_ipv4_address;
    logic [PORT_W-1:0] o_port_number;

    // decoder model state
    logic [ACC_W-1:0]   model_acc = '0;
    logic [COUNT_W-1:0] model_count = '0;
    logic               model_bad = 1'b0;

    t_endpoint   pending_endpoints [$];
    int unsigned words_sent = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    logic        steady = 1'b0;

    base32_endpoint_code_decoder uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_symbol       (i_symbol),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_valid_res    (o_valid_res),
        .o_ipv4_address (o_ipv4_address),
        .o_port_number  (o_port_number)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // symbol index to ascii, upper case
    function automatic logic [7:0] symbol_char(input logic [SYM_W-1:0] idx);
        if (idx < 8)       return 8'h41 + 8'(idx);
        else if (idx < 13) return 8'h4A + 8'(idx - 8);
        else if (idx < 24) return 8'h50 + 8'(idx - 13);
        else               return 8'h32 + 8'(idx - 24);
    endfunction

    // ascii to symbol index by ranges, case folded; hit low when not in the alphabet
    function automatic logic [SYM_W:0] char_index(input logic [7:0] ch);
        logic [7:0] up;
        up = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'h20 : ch;
        if (up >= 8'h41 && up <= 8'h48)      return {1'b1, SYM_W'(up - 8'h41)};
        else if (up >= 8'h4A && up <= 8'h4E) return {1'b1, SYM_W'(up - 8'h4A + 8)};
        else if (up >= 8'h50 && up <= 8'h5A) return {1'b1, SYM_W'(up - 8'h50 + 13)};
        else if (up >= 8'h32 && up <= 8'h39) return {1'b1, SYM_W'(up - 8'h32 + 24)};
        else                                 return '0;
    endfunction

    // advance the decoder model by one character
    task automatic decode_char(input logic [7:0] sym, input logic last,
                               output logic got, output t_endpoint ep);
        logic [SYM_W:0] look;
        look = char_index(sym);
        if (!look[SYM_W]) model_bad = 1'b1;
        model_acc = {model_acc[ACC_W-SYM_W-1:0], look[SYM_W-1:0]};
        if (model_count != COUNT_MAX) model_count = model_count + 1'b1;
        got = last;
        ep  = NO_ENDPOINT;
        if (last) begin
            if (!model_bad && model_count == COUNT_CODE) begin
                ep.ok   = 1'b1;
                ep.addr = model_acc[ACC_W-1:PORT_W];
                ep.port = model_acc[PORT_W-1:0];
            end
            model_acc   = '0;
            model_count = '0;
            model_bad   = 1'b0;
        end
    endtask

    // drive one word, wait for it to be taken, then record what it should give
    task automatic send_word(input logic [7:0] sym, input logic last,
                             input logic typed, input t_endpoint want);
        logic      got;
        t_endpoint ep;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_symbol <= sym;
        i_last   <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        words_sent++;
        decode_char(sym, last, got, ep);
        if (got) pending_endpoints.push_back(typed ? want : ep);
    endtask

    // hold the sender until every pending endpoint has come out
    task automatic drain();
        while (pending_endpoints.size() != 0) @(posedge i_clk);
    endtask

    // random in-alphabet character, random letter case
    function automatic logic [7:0] random_good_char();
        logic [7:0] ch;
        ch = symbol_char(SYM_W'($urandom_range(0, 31)));
        if (ch >= 8'h41 && $urandom_range(0, 1)) ch = ch + 8'h20;
        return ch;
    endfunction

    // one random code: mostly well formed, some with a bad character,
    // some of random length, some raw bytes
    task automatic send_random_code();
        int unsigned kind;
        int unsigned len;
        int unsigned bad_at;
        logic [7:0]  ch;
        kind   = $urandom_range(0, 99);
        len    = (kind < 75) ? CODE_LENGTH : $urandom_range(1, 20);
        bad_at = $urandom_range(0, len - 1);
        for (int unsigned k = 0; k < len; k++) begin
            if (kind >= 90 || (kind >= 60 && kind < 75 && k == bad_at))
                ch = 8'($urandom_range(0, 255));
            else
                ch = random_good_char();
            send_word(ch, k == len - 1, 1'b0, NO_ENDPOINT);
        end
    endtask

    // receiver stalls at random outside the steady stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_endpoint want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_endpoints.size() == 0) begin
                $error("unexpected result word: valid_res %0d address %h port %h",
                       o_valid_res, o_ipv4_address, o_port_number);
                mismatch_count++;
            end else begin
                want = pending_endpoints.pop_front();
                if (o_valid_res !== want.ok) begin
                    $error("valid_res: expected %0d, got %0d", want.ok, o_valid_res);
                    mismatch_count++;
                end
                if (o_ipv4_address !== want.addr) begin
                    $error("ipv4_address: expected %h, got %h", want.addr, o_ipv4_address);
                    mismatch_count++;
                end
                if (o_port_number !== want.port) begin
                    $error("port_number: expected %h, got %h", want.port, o_port_number);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int unsigned r = 0; r < DIRECTED_ROWS; r++) begin
            send_word(DIRECTED[r].sym, DIRECTED[r].last, DIRECTED[r].typed,
                      DIRECTED[r].want);
        end
        i_valid <= 1'b0;
        drain();

        while (words_sent < DIRECTED_ROWS + RANDOM_WORDS) begin
            steady = (words_sent >= 800 && words_sent < 1100);
            send_random_code();
            // let the output side empty out now and then
            if (!steady && $urandom_range(0, 99) < 3) begin
                i_valid <= 1'b0;
                drain();
            end
        end
        i_valid <= 1'b0;
        steady = 1'b0;

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_endpoints.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
